@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/oll_pkg.sv @@
// Types and constants of the ordered list engine.
package oll_pkg;

  localparam int DEPTH      = 64;
  localparam int WIDTH      = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 7;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_ERASE    = 3'd1,
    OP_SET      = 3'd2,
    OP_GET      = 3'd3,
    OP_POP_BACK = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_SET    = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [CMP_W-1:0]      pos;
    logic [WIDTH-1:0]      value;
  } cell_cmd_t;

endpackage

@@ design/oll_cell.sv @@
// One list entry: holds, loads, or takes a neighbour's entry.
module oll_cell import oll_pkg::*; (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [WIDTH-1:0]  lower_i,
  input  logic [WIDTH-1:0]  upper_i,
  output logic [WIDTH-1:0]  data_o
);

  logic [WIDTH-1:0] data_q;
  logic [WIDTH-1:0] data_d;
  logic [CMP_W-1:0] ix;

  always_comb begin
    ix     = CMP_W'(idx_i);
    data_d = data_q;
    unique case (cmd_i.kind)
      CMD_INSERT: begin
        if (ix == cmd_i.pos) begin
          data_d = cmd_i.value;
        end else if (ix > cmd_i.pos) begin
          data_d = lower_i;
        end
      end
      CMD_ERASE: begin
        if (ix >= cmd_i.pos) begin
          data_d = upper_i;
        end
      end
      CMD_SET: begin
        if (ix == cmd_i.pos) begin
          data_d = cmd_i.value;
        end
      end
      CMD_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ design/ordered_list_insert_erase.sv @@
// Ordered list engine: a row of entry cells with insert, erase, set, get, pop and clear.
//
//   channel   | direction | handshake        | payload
//   request   | in        | start_i / busy_o | op_i, position_i, value_i
//   result    | out       | done_o strobe    | status_o, read_value_o, count_o
//
// One request per cycle; busy_o stays low. The result is registered and appears in the
// cycle after acceptance: every cell shifts or loads in parallel at the accepting edge,
// and get reads the addressed cell through one selector into the result register.
// Reset clears the count and the strobe; entry contents stay undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_insert_erase import oll_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [VAL_W-1:0]    value_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [VAL_W-1:0]    read_value_o,
  output logic [COUNT_W-1:0]  count_o
);

  logic [WIDTH-1:0] cell_data [DEPTH];
  cell_cmd_t        cmd;
  logic [CNT_W-1:0] used_q, used_d;
  logic             done_q;
  status_e          status_q, status_d;
  logic [VAL_W-1:0] read_value_q, read_value_d;
  logic [CMP_W-1:0] pos_x, used_x;
  logic             full;

  assign busy_o = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    oll_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(i)),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[i])
    );
  end

  always_comb begin
    pos_x        = CMP_W'(position_i);
    used_x       = CMP_W'(used_q);
    full         = (used_q == CNT_W'(DEPTH));
    cmd.kind     = CMD_NONE;
    cmd.pos      = pos_x;
    cmd.value    = value_i[WIDTH-1:0];
    used_d       = used_q;
    status_d     = ST_OK;
    read_value_d = '0;
    if (start_i) begin
      unique case (op_e'(op_i))
        OP_INSERT: begin
          if (pos_x > used_x) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cmd.kind = CMD_INSERT;
            used_d   = used_q + CNT_W'(1);
          end
        end
        OP_ERASE: begin
          if (pos_x >= used_x) begin
            status_d = ST_RANGE;
          end else begin
            cmd.kind = CMD_ERASE;
            used_d   = used_q - CNT_W'(1);
          end
        end
        OP_SET: begin
          if (pos_x >= used_x) begin
            status_d = ST_RANGE;
          end else begin
            cmd.kind = CMD_SET;
          end
        end
        OP_GET: begin
          if (pos_x >= used_x) begin
            status_d = ST_RANGE;
          end else begin
            read_value_d = VAL_W'(cell_data[pos_x[IDX_W-1:0]]);
          end
        end
        OP_POP_BACK: begin
          if (used_q == '0) begin
            status_d = ST_RANGE;
          end else begin
            used_d = used_q - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          used_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      used_q   <= used_d;
      done_q   <= start_i;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_value_q <= read_value_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = read_value_q;
  assign count_o      = COUNT_W'(used_q);

endmodule

@@ design/oll_checker.sv @@
// Port-level checks of the ordered list engine, bound to the top level.
`include "assert_macros.svh"

module oll_checker import oll_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic                done_o,
  input  logic [STATUS_W-1:0] status_o,
  input  logic [VAL_W-1:0]    read_value_o,
  input  logic [COUNT_W-1:0]  count_o
);

  logic acc;
  assign acc = start_i && !busy_o;

  `ASSERT_NEXT(a_one_result, clk_i, rst_ni, 1'b1, done_o == $past(acc))
  `ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, acc && (op_i == OP_CLEAR),
               (count_o == '0) && (status_o == ST_OK))
  `ASSERT_IMPL(a_fail_reads_zero, clk_i, rst_ni, done_o && (status_o != ST_OK),
               read_value_o == '0)
  `ASSERT_IMPL(a_count_bounded, clk_i, rst_ni, done_o,
               (COUNT_W + 1)'(count_o) <= (COUNT_W + 1)'(DEPTH))

endmodule

bind ordered_list_insert_erase oll_checker u_oll_checker (.*);

@@ dv/ordered_list_insert_erase_tb.sv @@
// Testbench for the ordered list engine: directed and random requests checked against a list predictor.
`timescale 1ns / 1ps

module ordered_list_insert_erase_tb import oll_pkg::*; ();

  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [OP_W-1:0]     op_i;
  logic [POS_W-1:0]    position_i;
  logic [VAL_W-1:0]    value_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [VAL_W-1:0]    read_value_o;
  logic [COUNT_W-1:0]  count_o;

  logic [WIDTH-1:0] list_store [DEPTH];
  int               list_len;
  outcome_t         pending [$];
  bit               idle_on;
  int               cycles;
  int               requests;
  int               results_seen;
  int               mismatches;
  int               n_ok;
  int               n_range;
  int               n_full;
  int               peak_len;

  ordered_list_insert_erase DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic outcome_t apply_request(input logic [OP_W-1:0] op,
                                             input logic [POS_W-1:0] pos,
                                             input logic [VAL_W-1:0] val);
    outcome_t o;
    int       p;
    int       i;
    p = int'(pos);
    o.status = ST_OK;
    o.read_value = '0;
    case (op)
      OP_INSERT: begin
        if (p > list_len) begin
          o.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_store[i] = list_store[i-1];
          list_store[p] = val[WIDTH-1:0];
          list_len++;
        end
      end
      OP_ERASE: begin
        if (p >= list_len) begin
          o.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
          list_len--;
        end
      end
      OP_SET: begin
        if (p >= list_len) o.status = ST_RANGE;
        else list_store[p] = val[WIDTH-1:0];
      end
      OP_GET: begin
        if (p >= list_len) o.status = ST_RANGE;
        else o.read_value = VAL_W'(list_store[p]);
      end
      OP_POP_BACK: begin
        if (list_len == 0) o.status = ST_RANGE;
        else list_len--;
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    o.count = COUNT_W'(list_len);
    return o;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no request outstanding: status %0d read_value %h count %0d",
                   status_o, read_value_o, count_o);
      end else begin
        exp_o = pending.pop_front();
        if (status_o !== exp_o.status || read_value_o !== exp_o.read_value ||
            count_o !== exp_o.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: status %0d/%0d read_value %h/%h count %0d/%0d",
                     results_seen, exp_o.status, status_o, exp_o.read_value, read_value_o,
                     exp_o.count, count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    outcome_t o;
    @(negedge clk_i);
    start_i = 1'b1;
    op_i = op;
    position_i = pos;
    value_i = val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    o = apply_request(op, pos, val);
    pending.push_back(o);
    requests++;
    case (o.status)
      ST_OK: n_ok++;
      ST_RANGE: n_range++;
      default: n_full++;
    endcase
    if (list_len > peak_len) peak_len = list_len;
  endtask

  // hold start low for a random burst, with junk on the payload
  task automatic idle_gap();
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk_i);
      start_i = 1'b0;
      op_i = OP_W'($urandom());
      position_i = POS_W'($urandom());
      value_i = $urandom();
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
    if ($urandom_range(0, 6) == 0) return POS_W'($urandom_range(0, 127));
    if (op == OP_INSERT) return POS_W'($urandom_range(0, list_len));
    if (list_len == 0) return '0;
    return POS_W'($urandom_range(0, list_len - 1));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int grow_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20 + grow_bias) return OP_INSERT;
    if (r < 45) return OP_GET;
    if (r < 62 - grow_bias / 2) return OP_ERASE;
    if (r < 75) return OP_SET;
    if (r < 88 - grow_bias / 2) return OP_POP_BACK;
    if (r < 90) return OP_CLEAR;
    if (r < 95) return OP_RSVD6;
    if (r < 96) return OP_RSVD7;
    return OP_GET;
  endfunction

  task automatic random_request(input int grow_bias);
    logic [OP_W-1:0] op;
    op = pick_op(grow_bias);
    idle_gap();
    send_request(op, pick_position(op), pick_value());
  endtask

  task automatic test_empty_and_edges();
    send_request(OP_GET, 7'd0, 32'h1234_5678);
    send_request(OP_ERASE, 7'd0, '0);
    send_request(OP_SET, 7'd0, '1);
    send_request(OP_POP_BACK, 7'd0, '0);
    send_request(OP_INSERT, 7'd1, 32'hDEAD_BEEF);
    send_request(OP_CLEAR, 7'd0, '0);
    send_request(OP_RSVD6, 7'd0, '1);
    send_request(OP_RSVD7, 7'd127, '1);
    send_request(OP_INSERT, 7'd0, '0);
    send_request(OP_INSERT, 7'd1, '1);
    send_request(OP_INSERT, 7'd0, 32'hA5A5_5A5A);
    send_request(OP_GET, 7'd0, '0);
    send_request(OP_GET, 7'd1, '0);
    send_request(OP_GET, 7'd2, '0);
    send_request(OP_GET, 7'd3, '0);
    send_request(OP_SET, 7'd1, 32'h8000_0001);
    send_request(OP_ERASE, 7'd1, '0);
    send_request(OP_GET, 7'd1, '0);
    send_request(OP_GET, 7'd127, '0);
    send_request(OP_ERASE, 7'd64, '0);
    send_request(OP_RSVD6, 7'd1, '0);
    send_request(OP_POP_BACK, 7'd0, '0);
    send_request(OP_CLEAR, 7'd0, '0);
    send_request(OP_GET, 7'd0, '0);
  endtask

  task automatic test_fill_and_overflow();
    while (list_len < DEPTH) begin
      idle_gap();
      send_request(OP_INSERT, POS_W'($urandom_range(0, list_len)), pick_value());
    end
    send_request(OP_INSERT, 7'd64, '1);
    send_request(OP_INSERT, 7'd65, '1);
    send_request(OP_INSERT, 7'd0, '1);
    send_request(OP_INSERT, 7'd127, '0);
    send_request(OP_GET, 7'd63, '0);
    send_request(OP_GET, 7'd64, '0);
    send_request(OP_SET, 7'd63, '1);
    send_request(OP_GET, 7'd63, '0);
    send_request(OP_ERASE, 7'd0, '0);
    send_request(OP_INSERT, 7'd63, 32'h0F0F_F0F0);
    send_request(OP_ERASE, 7'd63, '0);
    send_request(OP_INSERT, 7'd63, 32'h1111_2222);
    for (int k = 0; k < DEPTH; k += 7) send_request(OP_GET, POS_W'(k), '0);
    while (list_len > 0) begin
      idle_gap();
      send_request(OP_POP_BACK, '0, pick_value());
    end
    send_request(OP_POP_BACK, 7'd0, '0);
  endtask

  task automatic test_random_mix(input int n);
    int bias;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        idle_on = ($urandom_range(0, 2) != 0);
        bias = $urandom_range(0, 1) ? 20 : -10;
      end
      random_request(bias);
    end
  endtask

  task automatic test_back_to_back(input int n);
    idle_on = 1'b0;
    for (int k = 0; k < n; k++) random_request((k / 30) % 2 ? -10 : 20);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = '0;
    position_i = '0;
    value_i = '0;
    idle_on = 1'b1;
    list_len = 0;
    cycles = 0;
    requests = 0;
    results_seen = 0;
    mismatches = 0;
    n_ok = 0;
    n_range = 0;
    n_full = 0;
    peak_len = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_edges();
    test_fill_and_overflow();
    test_random_mix(100);
    test_fill_and_overflow();
    test_back_to_back(90);

    @(negedge clk_i);
    start_i = 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d requests: %0d ok, %0d out of range, %0d full; longest list %0d",
             requests, n_ok, n_range, n_full, peak_len);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/oll_pkg.sv
design/oll_cell.sv
design/ordered_list_insert_erase.sv
design/oll_checker.sv
dv/ordered_list_insert_erase_tb.sv
